### src/plid_pkg.sv
package plid_pkg;

    // Operation carried by an input item
    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_DELETE = 1'b1
    } t_kind;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Broadcast command seen by every cell of the chain
    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_INS  = 2'd1,
        OP_DEL  = 2'd2
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cell_cmd;

    localparam int STATUS_W = 2;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int LENGTH_W = 5;

endpackage

### src/plid_cell.sv
module plid_cell
    import plid_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int DATA_WIDTH = 32,
    parameter int CW         = 5
) (
    input  logic                  i_clk,
    input  t_cell_cmd             i_cmd,
    input  logic [CW-1:0]         i_sel,
    input  logic [CW-1:0]         i_len,
    input  logic [DATA_WIDTH-1:0] i_new,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_data
);

    localparam logic [CW:0] IDX_W  = (CW+1)'(IDX);
    localparam logic [CW:0] IDX_P1 = (CW+1)'(IDX + 1);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic [CW:0]           sel_w;
    logic [CW:0]           len_w;

    assign sel_w = {1'b0, i_sel};
    assign len_w = {1'b0, i_len};

    always_comb begin
        n_data = r_data;
        unique case (i_cmd.op)
            OP_INS: begin
                // Load at the insertion slot, take from the left above it
                if (IDX_W == sel_w) begin
                    n_data = i_new;
                end else if (IDX_W > sel_w && IDX_W <= len_w) begin
                    n_data = i_left;
                end
            end
            OP_DEL: begin
                // Close the gap: take from the right from the removed slot on
                if (IDX_W >= sel_w && IDX_P1 < len_w) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

### src/positional_list_insert_delete_core.sv
// A registered result appears in the cycle after its item is accepted.
// Throughput: one item per cycle unless the output stalls; every cell shifts in
// the same cycle, so no operation iterates. The output register frees the input
// side whenever the pending result is taken or the output is empty.
// Reset (synchronous, active low) empties the list and the output register;
// slot contents are not cleared and there is no clearing pass.
module positional_list_insert_delete_core
    import plid_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_kind,
    input  logic [POS_W-1:0]    i_position,
    input  logic [VALUE_W-1:0]  i_value,
    // Output channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [VALUE_W-1:0]  o_removed_value,
    output logic [LENGTH_W-1:0] o_length_after
);

    // Count width holds CAPACITY itself; compare width also covers the position
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = (LW > POS_W) ? LW : POS_W;
    localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

    // Control and output registers
    logic [LW-1:0]       r_len;
    logic [LW-1:0]       n_len;
    logic                r_out_valid;
    t_status             r_status;
    t_status             n_status;
    logic [VALUE_W-1:0]  r_removed;
    logic [VALUE_W-1:0]  n_removed;

    logic                accept;
    t_kind               kind;
    logic [CW-1:0]       pos_w;
    logic [CW-1:0]       len_w;
    logic [CW-1:0]       del_sel;
    logic [CW-1:0]       cell_sel;
    t_cell_cmd           cell_cmd;
    logic                op_ok;
    logic [DATA_WIDTH-1:0] new_data;
    logic [DATA_WIDTH-1:0] slot_q [CAPACITY];
    logic [DATA_WIDTH-1:0] rd_data;

    // Hold the input whenever a finished result waits and is not taken
    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    assign kind    = t_kind'(i_kind);
    assign pos_w   = CW'(i_position);
    assign len_w   = CW'(r_len);
    assign del_sel = pos_w - CW'(1);

    assign new_data = DATA_WIDTH'(i_value);

    // Range check first, then the full check; pick the broadcast command
    always_comb begin
        n_status  = ST_DONE;
        op_ok     = 1'b0;
        n_len     = r_len;
        cell_sel  = pos_w;
        n_removed = '0;
        unique case (kind)
            KIND_INSERT: begin
                if (pos_w > len_w) begin
                    n_status = ST_RANGE;
                end else if (r_len == CAP_L) begin
                    n_status = ST_FULL;
                end else begin
                    op_ok = 1'b1;
                    n_len = r_len + LW'(1);
                end
            end
            KIND_DELETE: begin
                cell_sel = del_sel;
                if (pos_w == '0 || pos_w > len_w) begin
                    n_status = ST_RANGE;
                end else begin
                    op_ok     = 1'b1;
                    n_len     = r_len - LW'(1);
                    n_removed = VALUE_W'(rd_data);
                end
            end
            default: begin
                n_status = ST_RANGE;
            end
        endcase
    end

    always_comb begin
        cell_cmd.op = OP_NONE;
        if (accept && op_ok) begin
            cell_cmd.op = (kind == KIND_INSERT) ? OP_INS : OP_DEL;
        end
    end

    // Read the slot a delete removes; the value is used only for in-range deletes
    assign rd_data = slot_q[del_sel[IW-1:0]];

    // Chain of cells: each holds one slot and trades data with its neighbors
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;

        if (g == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = slot_q[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_mid_r
            assign right_d = slot_q[g+1];
        end

        plid_cell #(
            .IDX        (g),
            .DATA_WIDTH (DATA_WIDTH),
            .CW         (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cell_cmd),
            .i_sel   (cell_sel),
            .i_len   (len_w),
            .i_new   (new_data),
            .i_left  (left_d),
            .i_right (right_d),
            .o_data  (slot_q[g])
        );
    end

    // Advance the count and load the result together on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_len       <= n_len;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status  <= n_status;
            r_removed <= n_removed;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_removed_value = r_removed;
    assign o_length_after  = LENGTH_W'(r_len);

    // Count never exceeds the capacity
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= CAP_L)
        else $error("list count exceeds capacity");

    // Every accepted item leaves a result behind
    a_result_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("accepted item produced no result");

    // A successful delete shrinks the list by exactly one
    a_delete_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && kind == KIND_DELETE && op_ok |=> r_len == $past(r_len) - LW'(1))
        else $error("delete did not shrink the list");

    // A failed operation leaves the count alone and reports no value
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !op_ok |=> r_len == $past(r_len) && o_removed_value == '0)
        else $error("failed operation changed state");

endmodule
